/* src/assert_macros.svh */
// Assertion macros used by the port checker of the shifter block.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that implies another in the same cycle.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that implies another in the following cycle.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/dbssd_pkg.sv */
// Shared constants for the disk bit shifter with sync detection.
// Used by the core and by its port checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dbssd_pkg;

  // Request kinds carried on s_tuser.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ZONE0  = 3'd0;
  localparam logic [2:0] CFG_ZONE1  = 3'd1;
  localparam logic [2:0] CFG_ZONE2  = 3'd2;
  localparam logic [2:0] CFG_ZONE3  = 3'd3;
  localparam logic [2:0] CFG_SPINUP = 3'd4;

  localparam int CYC_W  = 6;
  localparam int SPIN_W = 24;

  localparam logic [CYC_W-1:0]  ZONE0_RESET  = 6'd32;
  localparam logic [CYC_W-1:0]  ZONE1_RESET  = 6'd30;
  localparam logic [CYC_W-1:0]  ZONE2_RESET  = 6'd28;
  localparam logic [CYC_W-1:0]  ZONE3_RESET  = 6'd26;
  localparam logic [SPIN_W-1:0] SPINUP_RESET = 24'd1000000;

  // A zone count of zero selects the fastest standard rate; small counts clamp.
  localparam logic [CYC_W-1:0] CYC_ZERO_DEFAULT = 6'd26;
  localparam logic [CYC_W-1:0] CYC_MIN          = 6'd8;
  localparam logic [6:0]       ACC_STEP         = 7'd8;
  localparam logic [3:0]       BITS_PER_BYTE    = 4'd8;
  localparam logic [9:0]       SYNC_ONES        = 10'h3FF;

  // Bit positions of the result fields in m_tdata.
  localparam int OUT_BYTE_READY = 0;
  localparam int OUT_PORT_LO    = 1;
  localparam int OUT_IN_SYNC    = 9;
  localparam int OUT_OVERFLOW   = 10;
  localparam int OUT_HEAD_ADV   = 11;
  localparam int OUT_PAINT_EN   = 12;
  localparam int OUT_PAINT_BIT  = 13;
  localparam int OUT_WRITE_MODE = 14;
  localparam int OUT_SPINDLE    = 15;

  function automatic logic [CYC_W-1:0] zone_count(input logic [CYC_W-1:0] c);
    logic [CYC_W-1:0] r;
    if (c == '0) begin
      r = CYC_ZERO_DEFAULT;
    end else if (c < CYC_MIN) begin
      r = CYC_MIN;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/disk_bit_shifter_sync_detect_core.sv */
// Floppy flux-side read/write shifter with sync detection, one request per tick.
// The result of each request is registered into m_tdata when the request is accepted.
// Throughput: one request per cycle; a waiting result does not block the next
// request as long as m_tready takes it in the same cycle.
// Reset (synchronous, active high) clears all state but m_tdata and loads the default zone
// counts and spin-up delay; no clearing pass follows.
`timescale 1ns / 1ps
`default_nettype none

module disk_bit_shifter_sync_detect_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata, low bit up: write_value[7:0], motor_request, write_request,
  // zone_select[1:0], flux_bit, track_present, media_valid, write_protect
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,
  // s_tuser: operation[1:0]
  input  wire logic [1:0]  s_tuser,
  // m_tdata, low bit up: byte_ready, port_data[7:0], in_sync, overflow_pulse,
  // head_advance, paint_enable, paint_bit, write_mode, spindle_ready
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [dbssd_pkg::SPIN_W-1:0] cfg_data
);

  import dbssd_pkg::*;

  logic [CYC_W-1:0]  cyc_zone [4];
  logic [SPIN_W-1:0] spinup_ticks;

  logic              motor_running, spindle_ok, write_active, sync_flag, ready_flag;
  logic              last_out_bit;
  logic [SPIN_W-1:0] spin_left;
  logic [6:0]        rate_acc;
  logic [9:0]        sync_window;
  logic [3:0]        bit_count, out_bits_left;
  logic [7:0]        read_shift, data_latch, out_shift;

  logic              motor_running_next, spindle_ok_next, write_active_next;
  logic              sync_flag_next, ready_flag_next, last_out_bit_next;
  logic [SPIN_W-1:0] spin_left_next;
  logic [6:0]        rate_acc_next;
  logic [9:0]        sync_window_next;
  logic [3:0]        bit_count_next, out_bits_left_next;
  logic [7:0]        read_shift_next, data_latch_next, out_shift_next;
  logic [15:0]       result_next;

  logic [7:0] in_wval;
  logic       in_motor, in_wreq, in_flux, in_trk, in_media, in_wprot;
  logic [1:0] in_zone;
  logic       accept;

  assign in_wval  = s_tdata[7:0];
  assign in_motor = s_tdata[8];
  assign in_wreq  = s_tdata[9];
  assign in_zone  = s_tdata[11:10];
  assign in_flux  = s_tdata[12];
  assign in_trk   = s_tdata[13];
  assign in_media = s_tdata[14];
  assign in_wprot = s_tdata[15];

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic             want, bit_val, pulse, adv, paint, pbit;
    logic [CYC_W-1:0] cpb;
    logic [6:0]       acc_sum;

    motor_running_next = motor_running;
    spindle_ok_next    = spindle_ok;
    write_active_next  = write_active;
    sync_flag_next     = sync_flag;
    ready_flag_next    = ready_flag;
    last_out_bit_next  = last_out_bit;
    spin_left_next     = spin_left;
    rate_acc_next      = rate_acc;
    sync_window_next   = sync_window;
    bit_count_next     = bit_count;
    out_bits_left_next = out_bits_left;
    read_shift_next    = read_shift;
    data_latch_next    = data_latch;
    out_shift_next     = out_shift;
    want    = 1'b0;
    bit_val = 1'b0;
    pulse   = 1'b0;
    adv     = 1'b0;
    paint   = 1'b0;
    pbit    = 1'b0;
    cpb     = zone_count(cyc_zone[in_zone]);
    acc_sum = rate_acc + ACC_STEP;

    unique case (s_tuser)
      OP_READ: begin
        if (!write_active) begin
          ready_flag_next = 1'b0;
        end
      end
      OP_WRITE: begin
        if (write_active) begin
          out_shift_next     = in_wval;
          out_bits_left_next = BITS_PER_BYTE;
          ready_flag_next    = 1'b0;
          data_latch_next    = in_wval;
        end
      end
      OP_TICK: begin
        if (in_motor && !motor_running) begin
          spin_left_next  = spinup_ticks;
          spindle_ok_next = 1'b0;
        end
        if (!in_motor) begin
          spindle_ok_next = 1'b0;
          spin_left_next  = '0;
        end
        motor_running_next = in_motor;

        want = in_wreq && spindle_ok_next;
        if (want && !write_active) begin
          write_active_next  = 1'b1;
          out_bits_left_next = '0;
          bit_count_next     = '0;
          ready_flag_next    = 1'b1;
          pulse              = 1'b1;
          sync_flag_next     = 1'b0;
        end else if (!want && write_active) begin
          write_active_next  = 1'b0;
          out_bits_left_next = '0;
          bit_count_next     = '0;
        end

        if (in_motor && !spindle_ok_next) begin
          if (spin_left_next != '0) begin
            spin_left_next = spin_left_next - 1'b1;
          end
          if (spin_left_next == '0) begin
            spindle_ok_next = 1'b1;
          end
        end

        if (spindle_ok_next && in_media) begin
          rate_acc_next = acc_sum;
          if (acc_sum >= {1'b0, cpb}) begin
            rate_acc_next = acc_sum - {1'b0, cpb};
            if (write_active_next) begin
              if (!in_wprot) begin
                if (out_bits_left_next != '0) begin
                  bit_val            = out_shift_next[7];
                  out_shift_next     = {out_shift_next[6:0], 1'b0};
                  out_bits_left_next = out_bits_left_next - 1'b1;
                  last_out_bit_next  = bit_val;
                  bit_count_next     = '0;
                  if (in_trk) begin
                    paint = 1'b1;
                    pbit  = bit_val;
                  end
                  if (out_bits_left_next == '0) begin
                    ready_flag_next = 1'b1;
                    pulse           = 1'b1;
                  end
                end else begin
                  // No byte latched: keep driving the last bit and time an idle byte.
                  bit_val        = last_out_bit_next;
                  bit_count_next = bit_count_next + 1'b1;
                  if (bit_count_next >= BITS_PER_BYTE) begin
                    bit_count_next  = '0;
                    ready_flag_next = 1'b1;
                    pulse           = 1'b1;
                  end
                end
                sync_window_next = {sync_window_next[8:0], bit_val};
                sync_flag_next   = (sync_window_next == SYNC_ONES);
              end else if (out_bits_left_next != '0) begin
                out_shift_next     = {out_shift_next[6:0], 1'b0};
                out_bits_left_next = out_bits_left_next - 1'b1;
                if (out_bits_left_next == '0) begin
                  ready_flag_next = 1'b1;
                  pulse           = 1'b1;
                end
              end
            end else begin
              bit_val          = in_trk && in_flux;
              sync_window_next = {sync_window_next[8:0], bit_val};
              sync_flag_next   = (sync_window_next == SYNC_ONES);
              if (sync_flag_next) begin
                bit_count_next  = '0;
                read_shift_next = '0;
              end else begin
                read_shift_next = {read_shift_next[6:0], bit_val};
                bit_count_next  = bit_count_next + 1'b1;
                if (bit_count_next >= BITS_PER_BYTE) begin
                  bit_count_next  = '0;
                  data_latch_next = read_shift_next;
                  ready_flag_next = 1'b1;
                  pulse           = 1'b1;
                end
              end
            end
            adv = in_trk;
          end
        end
      end
      default: begin
      end
    endcase

    result_next = {spindle_ok_next, write_active_next, pbit, paint, adv, pulse,
                   sync_flag_next, data_latch_next, ready_flag_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cyc_zone[0]  <= ZONE0_RESET;
      cyc_zone[1]  <= ZONE1_RESET;
      cyc_zone[2]  <= ZONE2_RESET;
      cyc_zone[3]  <= ZONE3_RESET;
      spinup_ticks <= SPINUP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ZONE0:  cyc_zone[0]  <= cfg_data[CYC_W-1:0];
        CFG_ZONE1:  cyc_zone[1]  <= cfg_data[CYC_W-1:0];
        CFG_ZONE2:  cyc_zone[2]  <= cfg_data[CYC_W-1:0];
        CFG_ZONE3:  cyc_zone[3]  <= cfg_data[CYC_W-1:0];
        CFG_SPINUP: spinup_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_running <= 1'b0;
      spindle_ok    <= 1'b0;
      write_active  <= 1'b0;
      sync_flag     <= 1'b0;
      ready_flag    <= 1'b0;
      last_out_bit  <= 1'b0;
      spin_left     <= '0;
      rate_acc      <= '0;
      sync_window   <= '0;
      bit_count     <= '0;
      out_bits_left <= '0;
      read_shift    <= '0;
      data_latch    <= '0;
      out_shift     <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept) begin
        motor_running <= motor_running_next;
        spindle_ok    <= spindle_ok_next;
        write_active  <= write_active_next;
        sync_flag     <= sync_flag_next;
        ready_flag    <= ready_flag_next;
        last_out_bit  <= last_out_bit_next;
        spin_left     <= spin_left_next;
        rate_acc      <= rate_acc_next;
        sync_window   <= sync_window_next;
        bit_count     <= bit_count_next;
        out_bits_left <= out_bits_left_next;
        read_shift    <= read_shift_next;
        data_latch    <= data_latch_next;
        out_shift     <= out_shift_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result_next;
    end
  end

endmodule

`default_nettype wire

/* src/dbssd_checker.sv */
// Port-level checker for the disk bit shifter core, attached by bind.
// Depends on dbssd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dbssd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  import dbssd_pkg::*;

  // The output register must never refuse a request while it is empty.
  `CHK_IMPLY(a_ready_when_empty, !m_tvalid, s_tready, "s_tready low with empty output")

  // A stalled result stays put.
  `CHK_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

  // Painting happens only in write mode, at a head advance.
  `CHK_IMPLY(a_paint_in_write, m_tvalid && m_tdata[OUT_PAINT_EN], m_tdata[OUT_WRITE_MODE] && m_tdata[OUT_HEAD_ADV], "paint outside write mode or advance")

  // Every overflow pulse comes with byte-ready set.
  `CHK_IMPLY(a_pulse_sets_ready, m_tvalid && m_tdata[OUT_OVERFLOW], m_tdata[OUT_BYTE_READY], "overflow pulse without byte ready")

  // Without painting the paint bit reads as zero.
  `CHK_IMPLY(a_paint_bit_idle, m_tvalid && !m_tdata[OUT_PAINT_EN], !m_tdata[OUT_PAINT_BIT], "paint bit set while paint disabled")

endmodule

bind disk_bit_shifter_sync_detect_core dbssd_checker u_dbssd_checker (.*);

`default_nettype wire
